/* sv/tuim_pkg.sv */
// Package with types, constants and register codes for the tensor unfold index map.
package tuim_pkg;

    localparam int MAX_MODES   = 4;
    localparam int FIELD_MODES = 4;
    localparam int COL_W       = 48;
    localparam int IDX_W       = 16;
    localparam int DIV_STAGES  = COL_W;

    localparam int MODE_LIMIT = (MAX_MODES < FIELD_MODES) ? MAX_MODES : FIELD_MODES;
    localparam logic [2:0] MODE_LIMIT_W = 3'(MODE_LIMIT);

    localparam logic [2:0] REG_MODE_COUNT  = 3'd0;
    localparam logic [2:0] REG_UNFOLD_MODE = 3'd1;
    localparam logic [2:0] REG_SIZE_MODE0  = 3'd2;
    localparam logic [2:0] REG_SIZE_MODE1  = 3'd3;
    localparam logic [2:0] REG_SIZE_MODE2  = 3'd4;
    localparam logic [2:0] REG_SIZE_MODE3  = 3'd5;

    localparam logic ACT_TO_MATRIX = 1'b0;
    localparam logic ACT_TO_TENSOR = 1'b1;

    typedef struct packed {
        logic              action;
        logic [IDX_W-1:0]  coord0_in;
        logic [IDX_W-1:0]  coord1_in;
        logic [IDX_W-1:0]  coord2_in;
        logic [IDX_W-1:0]  coord3_in;
        logic [IDX_W-1:0]  row_in;
        logic [COL_W-1:0]  column_in;
    } s_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]  coord0_out;
        logic [IDX_W-1:0]  coord1_out;
        logic [IDX_W-1:0]  coord2_out;
        logic [IDX_W-1:0]  coord3_out;
        logic [IDX_W-1:0]  row_out;
        logic [COL_W-1:0]  column_out;
    } m_item_t;

    // Settled configuration as seen by the datapath.
    typedef struct packed {
        logic [2:0]                        modes;
        logic [1:0]                        row_mode;
        logic [FIELD_MODES-1:0][COL_W-1:0] stride;
    } cfg_t;

    // Item traveling through the pipeline.
    typedef struct packed {
        logic              act;
        logic [IDX_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [COL_W-1:0]  rem;
        logic [IDX_W-1:0]  q1;
        logic [IDX_W-1:0]  q2;
    } pipe_t;

endpackage

/* sv/tuim_cfg.sv */
// Configuration registers and the stride table sequencer.
module tuim_cfg
    import tuim_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        wr_en,
    input  logic [2:0]  wr_index,
    input  logic [15:0] wr_data,
    output cfg_t        cfg,
    output logic        busy
);

    logic [2:0]             mode_count_reg;
    logic [1:0]             unfold_reg;
    logic [IDX_W-1:0]       size_reg [FIELD_MODES];
    logic [COL_W-1:0]       stride_reg [FIELD_MODES];
    logic [1:0]             step_reg;
    logic [2:0]             modes;
    logic [1:0]             row_mode;
    logic [1:0]             src_mode;
    logic [1:0]             prev_step;
    logic [COL_W+IDX_W-1:0] product;
    logic                   step_on;
    logic                   wr_known;

    always_comb begin
        if (mode_count_reg == 3'd0) begin
            modes = 3'd1;
        end else if (mode_count_reg > MODE_LIMIT_W) begin
            modes = MODE_LIMIT_W;
        end else begin
            modes = mode_count_reg;
        end
        row_mode = ({1'b0, unfold_reg} >= modes) ? 2'd0 : unfold_reg;
    end

    // Stride entry k is entry k-1 times the extent of the (k-1)-th mode other than the row mode.
    always_comb begin
        prev_step = step_reg - 2'd1;
        src_mode  = (prev_step >= row_mode) ? step_reg : prev_step;
        product   = stride_reg[prev_step] * size_reg[src_mode];
        step_on   = ({1'b0, step_reg} < modes);
        wr_known  = (wr_index <= REG_SIZE_MODE3);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_count_reg <= 3'd2;
            unfold_reg     <= 2'd0;
            step_reg       <= 2'd0;
            for (int i = 0; i < FIELD_MODES; i++) begin
                size_reg[i]   <= IDX_W'(1);
                stride_reg[i] <= COL_W'(1);
            end
        end else begin
            if (step_reg != 2'd0) begin
                stride_reg[step_reg] <= step_on ? product[COL_W-1:0] : COL_W'(1);
            end
            // A known write restarts the rebuild, even in the middle of one.
            if (wr_en && wr_known) begin
                step_reg <= 2'd1;
            end else if (step_reg != 2'd0) begin
                step_reg <= (step_reg == 2'd3) ? 2'd0 : step_reg + 2'd1;
            end
            if (wr_en) begin
                case (wr_index)
                    REG_MODE_COUNT:  mode_count_reg <= wr_data[2:0];
                    REG_UNFOLD_MODE: unfold_reg     <= wr_data[1:0];
                    REG_SIZE_MODE0:  size_reg[0]    <= wr_data;
                    REG_SIZE_MODE1:  size_reg[1]    <= wr_data;
                    REG_SIZE_MODE2:  size_reg[2]    <= wr_data;
                    REG_SIZE_MODE3:  size_reg[3]    <= wr_data;
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        cfg.modes    = modes;
        cfg.row_mode = row_mode;
        for (int i = 0; i < FIELD_MODES; i++) begin
            cfg.stride[i] = stride_reg[i];
        end
    end

    assign busy = (step_reg != 2'd0);

endmodule

/* sv/tuim_front.sv */
// Front stages: index decode, stride products and the column sum.
module tuim_front
    import tuim_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    en,
    input  logic    in_valid,
    input  s_item_t in_item,
    input  cfg_t    cfg,
    output logic    out_valid,
    output pipe_t   out_item
);

    // Stage 1: zero-based indices of the non-row modes, in rising order.
    logic             v1_reg, act1_reg;
    logic [IDX_W-1:0] row1_reg;
    logic [COL_W-1:0] rem1_reg;
    logic [IDX_W-1:0] d1_reg [3];
    logic             z1_reg [3];
    logic             on1_reg [3];
    // Stage 2: partial products.
    logic             v2_reg, act2_reg;
    logic [IDX_W-1:0] row2_reg;
    logic [COL_W-1:0] rem2_reg;
    logic [39:0]      pl2_reg [1:2];
    logic [39:0]      ph2_reg [1:2];
    logic             z2_reg [1:2];
    logic             on2_reg [1:2];
    logic [COL_W-1:0] t02_reg;
    // Stage 3: weighted terms.
    logic             v3_reg, act3_reg;
    logic [IDX_W-1:0] row3_reg;
    logic [COL_W-1:0] rem3_reg;
    logic [COL_W-1:0] t3_reg [3];
    // Stage 4: column.
    logic             v4_reg;
    pipe_t            item4_reg;

    logic [IDX_W-1:0] cin [FIELD_MODES];
    logic [IDX_W-1:0] sel_c [3];
    logic [1:0]       sel_m [3];
    logic [COL_W-1:0] term [1:2];

    always_comb begin
        cin[0] = in_item.coord0_in;
        cin[1] = in_item.coord1_in;
        cin[2] = in_item.coord2_in;
        cin[3] = in_item.coord3_in;
        for (int j = 0; j < 3; j++) begin
            sel_m[j] = (2'(j) >= cfg.row_mode) ? 2'(j + 1) : 2'(j);
            sel_c[j] = cin[sel_m[j]];
        end
    end

    always_comb begin
        for (int j = 1; j < 3; j++) begin
            if (!on2_reg[j]) begin
                term[j] = '0;
            end else if (z2_reg[j]) begin
                term[j] = ~cfg.stride[j] + COL_W'(1);
            end else begin
                term[j] = {8'd0, pl2_reg[j]} + {ph2_reg[j][23:0], 24'd0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            act1_reg <= in_item.action;
            row1_reg <= (in_item.action == ACT_TO_TENSOR) ? in_item.row_in : cin[cfg.row_mode];
            rem1_reg <= in_item.column_in - COL_W'(1);
            for (int j = 0; j < 3; j++) begin
                d1_reg[j]  <= sel_c[j] - IDX_W'(1);
                z1_reg[j]  <= (sel_c[j] == '0);
                on1_reg[j] <= (3'(j + 2) <= cfg.modes);
            end

            act2_reg <= act1_reg;
            row2_reg <= row1_reg;
            rem2_reg <= rem1_reg;
            for (int j = 1; j < 3; j++) begin
                pl2_reg[j] <= d1_reg[j] * cfg.stride[j][23:0];
                ph2_reg[j] <= d1_reg[j] * cfg.stride[j][47:24];
                z2_reg[j]  <= z1_reg[j];
                on2_reg[j] <= on1_reg[j];
            end
            if (!on1_reg[0]) begin
                t02_reg <= '0;
            end else if (z1_reg[0]) begin
                t02_reg <= '1;
            end else begin
                t02_reg <= {32'd0, d1_reg[0]};
            end

            act3_reg <= act2_reg;
            row3_reg <= row2_reg;
            rem3_reg <= rem2_reg;
            t3_reg[0] <= t02_reg;
            t3_reg[1] <= term[1];
            t3_reg[2] <= term[2];

            item4_reg.act <= act3_reg;
            item4_reg.row <= row3_reg;
            item4_reg.rem <= rem3_reg;
            item4_reg.col <= COL_W'(1) + t3_reg[0] + t3_reg[1] + t3_reg[2];
            item4_reg.q1  <= '0;
            item4_reg.q2  <= '0;
        end
    end

    assign out_valid = v4_reg;
    assign out_item  = item4_reg;

endmodule

/* sv/tuim_div.sv */
// Restoring divider, one quotient bit per pipeline stage.
module tuim_div
    import tuim_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             active,
    input  logic [COL_W-1:0] divisor,
    input  logic             in_valid,
    input  pipe_t            in_item,
    output logic             out_valid,
    output pipe_t            out_item,
    output logic [IDX_W-1:0] out_q,
    output logic [COL_W-1:0] out_rem
);

    logic             v_reg   [DIV_STAGES];
    pipe_t            item_reg[DIV_STAGES];
    logic [COL_W-1:0] r_reg   [DIV_STAGES];
    logic [COL_W-1:0] num_reg [DIV_STAGES];
    logic [IDX_W-1:0] q_reg   [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        logic             src_v;
        pipe_t            src_item;
        logic [COL_W-1:0] src_r, src_num;
        logic [IDX_W-1:0] src_q;
        logic [COL_W:0]   trial;
        logic             ge;

        if (s == 0) begin : g_first
            assign src_v    = in_valid;
            assign src_item = in_item;
            assign src_r    = '0;
            assign src_num  = in_item.rem;
            assign src_q    = '0;
        end else begin : g_next
            assign src_v    = v_reg[s-1];
            assign src_item = item_reg[s-1];
            assign src_r    = r_reg[s-1];
            assign src_num  = num_reg[s-1];
            assign src_q    = q_reg[s-1];
        end

        assign trial = {src_r, src_num[COL_W-1]};
        assign ge    = (trial >= {1'b0, divisor});

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[s] <= 1'b0;
            end else if (en) begin
                v_reg[s] <= src_v;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                item_reg[s] <= src_item;
                r_reg[s]    <= ge ? COL_W'(trial - {1'b0, divisor}) : trial[COL_W-1:0];
                num_reg[s]  <= {src_num[COL_W-2:0], 1'b0};
                q_reg[s]    <= {src_q[IDX_W-2:0], ge};
            end
        end
    end

    assign out_valid = v_reg[DIV_STAGES-1];
    assign out_item  = item_reg[DIV_STAGES-1];
    assign out_q     = q_reg[DIV_STAGES-1];
    assign out_rem   = active ? r_reg[DIV_STAGES-1] : item_reg[DIV_STAGES-1].rem;

endmodule

/* sv/tensor_unfold_index_map_core.sv */
// Top level of the tensor unfold index map: coordinate conversion pipeline.
//
//  Channel  Ports                                   Direction  Payload
//  input    s_valid, s_ready, s_data                in         s_item_t
//  result   m_valid, m_ready, m_data                out        m_item_t
//  config   cfg_valid, cfg_ready, cfg_index, cfg_data  in      index 3 bits, data 16 bits
//
// One item is accepted per cycle while s_ready is high, and each item passes 101 register
// stages: four front stages, two 48-stage restoring dividers (one quotient bit per stage)
// and the output register. The divider depth is set by the 48-bit column.
// Reset is synchronous and active low; it clears all valid bits and loads the reset
// configuration with a stride table of all ones.
// When the result is held by the sink, every stage holds in place and s_ready drops, so no
// item is lost or repeated. After a write to a known register, stride entries one to three
// are rebuilt, one entry per cycle through one multiplier, and s_ready stays low meanwhile.
module tensor_unfold_index_map_core
    import tuim_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  s_item_t     s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output m_item_t     m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    cfg_t             cfg;
    logic             busy;
    logic             en;
    logic             f_valid, d2_valid, d1_valid;
    pipe_t            f_item, d2_raw, d2_item, d1_raw, fin;
    logic [IDX_W-1:0] d2_q, d1_q;
    logic [COL_W-1:0] d2_rem, d1_rem;
    logic             m_valid_reg;
    m_item_t          m_data_reg, m_data_next;
    logic [IDX_W-1:0] qv   [3];
    logic [IDX_W-1:0] cout [FIELD_MODES];
    logic [1:0]       qidx [FIELD_MODES];

    // The whole pipeline advances together whenever the output register can take a result.
    assign en        = !m_valid_reg || m_ready;
    assign s_ready   = en && !busy;
    assign cfg_ready = 1'b1;

    tuim_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg),
        .busy     (busy)
    );

    tuim_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid && s_ready),
        .in_item   (s_data),
        .cfg       (cfg),
        .out_valid (f_valid),
        .out_item  (f_item)
    );

    // The highest stride is used first; it only applies when all four modes are in use.
    tuim_div u_div2 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .active    (cfg.modes == 3'd4),
        .divisor   (cfg.stride[2]),
        .in_valid  (f_valid),
        .in_item   (f_item),
        .out_valid (d2_valid),
        .out_item  (d2_raw),
        .out_q     (d2_q),
        .out_rem   (d2_rem)
    );

    always_comb begin
        d2_item     = d2_raw;
        d2_item.rem = d2_rem;
        d2_item.q2  = d2_q;
    end

    tuim_div u_div1 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .active    (cfg.modes >= 3'd3),
        .divisor   (cfg.stride[1]),
        .in_valid  (d2_valid),
        .in_item   (d2_item),
        .out_valid (d1_valid),
        .out_item  (d1_raw),
        .out_q     (d1_q),
        .out_rem   (d1_rem)
    );

    always_comb begin
        fin     = d1_raw;
        fin.rem = d1_rem;
        fin.q1  = d1_q;
    end

    // The lowest stride is one, so the last quotient is the remainder left after the dividers.
    always_comb begin
        qv[0] = fin.rem[IDX_W-1:0];
        qv[1] = fin.q1;
        qv[2] = fin.q2;
        for (int i = 0; i < FIELD_MODES; i++) begin
            qidx[i] = (2'(i) > cfg.row_mode) ? 2'(i - 1) : 2'(i);
            if (fin.act == ACT_TO_MATRIX) begin
                cout[i] = '0;
            end else if (2'(i) == cfg.row_mode) begin
                cout[i] = fin.row;
            end else if (3'(i) < cfg.modes) begin
                cout[i] = qv[qidx[i]] + IDX_W'(1);
            end else begin
                cout[i] = '0;
            end
        end
        m_data_next.coord0_out = cout[0];
        m_data_next.coord1_out = cout[1];
        m_data_next.coord2_out = cout[2];
        m_data_next.coord3_out = cout[3];
        m_data_next.row_out    = (fin.act == ACT_TO_MATRIX) ? fin.row : '0;
        m_data_next.column_out = (fin.act == ACT_TO_MATRIX) ? fin.col : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= d1_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* sv/tuim_checker.sv */
// Port checker for the tensor unfold index map and its bind to the top level.
module tuim_checker
    import tuim_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input m_item_t     m_data,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [2:0]  cfg_index
);

    // A held result stays put until it is taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // A nonzero column only comes from a tensor-to-matrix item, which leaves all coordinates zero.
    a_col_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.column_out != '0) |->
            (m_data.coord0_out == '0) && (m_data.coord1_out == '0) &&
            (m_data.coord2_out == '0) && (m_data.coord3_out == '0))
        else $error("column and coordinates both set");

    // A nonzero coord0 only comes from a matrix-to-tensor item, which leaves row and column zero.
    a_coord_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.coord0_out != '0) |->
            (m_data.row_out == '0) && (m_data.column_out == '0))
        else $error("coordinate and matrix position both set");

    // The stride rebuild after a known register write blocks new items.
    a_rebuild: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_ready && (cfg_index <= REG_SIZE_MODE3) |=> !s_ready)
        else $error("item taken during stride rebuild");

endmodule

bind tensor_unfold_index_map_core tuim_checker u_tuim_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_data    (m_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index)
);

/* tb/tb_tensor_unfold_index_map_core.sv */
// Self-checking testbench for the tensor unfold index map core.
module tb_tensor_unfold_index_map_core;
    import tuim_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY    = 101;
    localparam int STALL_LIMIT = 20000;
    localparam logic [COL_W-1:0] COL_ONES = '1;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    s_item_t     s_data;
    logic        m_valid;
    logic        m_ready;
    m_item_t     m_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    // Shadow copy of the block's configuration and its stride table.
    logic [2:0]       mode_count_q;
    logic [1:0]       unfold_mode_q;
    logic [IDX_W-1:0] extent_q [FIELD_MODES];
    logic [COL_W-1:0] stride_q [FIELD_MODES];

    m_item_t expected_results [$];
    int      mismatches;
    int      results_seen;
    int      items_sent;
    int      idle_cycles;
    int      settings_used;
    int      unsigned stall_pattern;

    tensor_unfold_index_map_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Effective mode count after clamping, and the mode that becomes the row.
    function automatic int active_modes();
        int m;
        m = int'(mode_count_q);
        if (m < 1) m = 1;
        if (m > MODE_LIMIT) m = MODE_LIMIT;
        return m;
    endfunction

    function automatic int row_mode_of(int m);
        return (int'(unfold_mode_q) >= m) ? 0 : int'(unfold_mode_q);
    endfunction

    // Strides are products of the non-row extents in rising mode order.
    task automatic rebuild_strides();
        int m;
        int n;
        int k;
        m = active_modes();
        n = row_mode_of(m);
        k = 1;
        for (int i = 0; i < FIELD_MODES; i++) stride_q[i] = 1;
        for (int i = 0; i < m; i++) begin
            if (i != n && k < FIELD_MODES) begin
                stride_q[k] = stride_q[k-1] * COL_W'(extent_q[i]);
                k++;
            end
        end
    endtask

    function automatic m_item_t map_coordinates(s_item_t it);
        m_item_t r;
        int m;
        int n;
        int k;
        logic [COL_W-1:0] col;
        logic [COL_W-1:0] rem;
        logic [COL_W-1:0] q;
        logic [IDX_W-1:0] c_in [FIELD_MODES];
        logic [IDX_W-1:0] c_out [FIELD_MODES];
        r = '0;
        m = active_modes();
        n = row_mode_of(m);
        c_in[0] = it.coord0_in;
        c_in[1] = it.coord1_in;
        c_in[2] = it.coord2_in;
        c_in[3] = it.coord3_in;
        for (int i = 0; i < FIELD_MODES; i++) c_out[i] = '0;
        if (it.action == ACT_TO_MATRIX) begin
            col = 1;
            k = 0;
            for (int i = 0; i < m; i++) begin
                if (i != n) begin
                    col = col + (COL_W'(c_in[i]) - 1) * stride_q[k];
                    k++;
                end
            end
            r.row_out = c_in[n];
            r.column_out = col;
        end else begin
            rem = it.column_in - 1;
            k = m - 2;
            for (int i = m - 1; i >= 0; i--) begin
                if (i == n) begin
                    c_out[i] = it.row_in;
                end else if (k >= 0) begin
                    if (stride_q[k] == 0) begin
                        q = COL_ONES;
                    end else begin
                        q = rem / stride_q[k];
                        rem = rem % stride_q[k];
                    end
                    c_out[i] = IDX_W'(q + 1);
                    k--;
                end
            end
            r.coord0_out = c_out[0];
            r.coord1_out = c_out[1];
            r.coord2_out = c_out[2];
            r.coord3_out = c_out[3];
        end
        return r;
    endfunction

    // Send one item, then maybe leave the channel idle for a random gap.
    task automatic send_item(s_item_t it);
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_results.push_back(map_coordinates(it));
        items_sent++;
        if ($urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
    endtask

    // Registers are only written with the pipeline empty. The caller drops cfg_valid
    // after the last write of a sequence.
    task automatic write_register(logic [2:0] idx, logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_MODE_COUNT:  mode_count_q  = value[2:0];
            REG_UNFOLD_MODE: unfold_mode_q = value[1:0];
            REG_SIZE_MODE0:  extent_q[0]   = value;
            REG_SIZE_MODE1:  extent_q[1]   = value;
            REG_SIZE_MODE2:  extent_q[2]   = value;
            REG_SIZE_MODE3:  extent_q[3]   = value;
            default: ;
        endcase
        rebuild_strides();
    endtask

    task automatic apply_setting(logic [2:0] modes, logic [1:0] row_mode,
                                 logic [15:0] e0, logic [15:0] e1,
                                 logic [15:0] e2, logic [15:0] e3);
        drain();
        write_register(REG_MODE_COUNT, 16'(modes));
        write_register(REG_UNFOLD_MODE, 16'(row_mode));
        write_register(REG_SIZE_MODE0, e0);
        write_register(REG_SIZE_MODE1, e1);
        write_register(REG_SIZE_MODE2, e2);
        write_register(REG_SIZE_MODE3, e3);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [15:0] random_index();
        case ($urandom_range(0, 3))
            0: return 16'd1;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly a coordinate inside the configured tensor, sometimes anything at all.
    function automatic s_item_t random_item();
        s_item_t it;
        logic [COL_W-1:0] span;
        it.action    = 1'($urandom);
        it.coord0_in = random_index();
        it.coord1_in = random_index();
        it.coord2_in = random_index();
        it.coord3_in = random_index();
        it.row_in    = random_index();
        it.column_in = {16'($urandom), 32'($urandom)};
        if ($urandom_range(0, 3) != 0) begin
            it.coord0_in = 16'($urandom_range(1, extent_q[0] == 0 ? 1 : int'(extent_q[0])));
            it.coord1_in = 16'($urandom_range(1, extent_q[1] == 0 ? 1 : int'(extent_q[1])));
            it.coord2_in = 16'($urandom_range(1, extent_q[2] == 0 ? 1 : int'(extent_q[2])));
            it.coord3_in = 16'($urandom_range(1, extent_q[3] == 0 ? 1 : int'(extent_q[3])));
            span = stride_q[active_modes() - 1];
            if (span != 0) it.column_in = (it.column_in % span) + 1;
        end
        return it;
    endfunction

    // Directed items: extremes of every field under both actions.
    task automatic test_extremes();
        s_item_t it;
        for (int a = 0; a < 2; a++) begin
            it = '0;
            it.action = a[0];
            it.coord0_in = 1; it.coord1_in = 1; it.coord2_in = 1; it.coord3_in = 1;
            it.row_in = 1; it.column_in = 1;
            send_item(it);
            it.coord0_in = '1; it.coord1_in = '1; it.coord2_in = '1; it.coord3_in = '1;
            it.row_in = '1; it.column_in = '1;
            send_item(it);
            // Out-of-range zero index and zero column wrap around.
            it = '0;
            it.action = a[0];
            send_item(it);
        end
    endtask

    task automatic test_random_block(int count);
        for (int i = 0; i < count; i++) send_item(random_item());
    endtask

    // Setting sweep: full and small tensors, row mode beyond the count,
    // mode counts zero and above the limit, zero extents.
    task automatic test_settings();
        apply_setting(3'd4, 2'd2, 16'd3, 16'd5, 16'd7, 16'd2);
        test_extremes();
        test_random_block(150);
        apply_setting(3'd4, 2'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        test_extremes();
        test_random_block(150);
        apply_setting(3'd1, 2'd0, 16'd9, 16'd1, 16'd1, 16'd1);
        test_random_block(80);
        apply_setting(3'd2, 2'd3, 16'd4, 16'd6, 16'd1, 16'd1);
        test_random_block(100);
        apply_setting(3'd0, 2'd1, 16'd5, 16'd5, 16'd5, 16'd5);
        test_random_block(60);
        apply_setting(3'd7, 2'd1, 16'd2, 16'd3, 16'd4, 16'd5);
        test_random_block(100);
        apply_setting(3'd3, 2'd1, 16'd0, 16'd8, 16'd0, 16'd1);
        test_extremes();
        test_random_block(100);
        apply_setting(3'd3, 2'd0, 16'd1, 16'd0, 16'd12, 16'd1);
        test_random_block(60);
        // An unknown register index must leave everything unchanged.
        drain();
        write_register(3'd6, 16'hFFFF);
        write_register(3'd7, 16'h0000);
        cfg_valid <= 1'b0;
        test_random_block(50);
    endtask

    task automatic test_random_settings(int rounds);
        for (int r = 0; r < rounds; r++) begin
            apply_setting(3'($urandom_range(0, 7)), 2'($urandom),
                          16'($urandom_range(0, 40)), 16'($urandom_range(1, 300)),
                          ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 20)),
                          16'($urandom_range(1, 9)));
            test_random_block(90);
        end
    endtask

    // Result check: compare every accepted result with the oldest expectation.
    always @(posedge aclk) begin
        m_item_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result %h", m_data);
            end else begin
                exp_r = expected_results.pop_front();
                if (m_data !== exp_r) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected %h got %h", exp_r, m_data);
                end
            end
        end
    end

    // The receiver stalls on a rotating pattern, with quiet stretches between.
    always @(posedge aclk) begin
        logic [31:0] pattern_next;
        if (!aresetn) begin
            m_ready <= 1'b1;
        end else begin
            pattern_next = {stall_pattern[30:0], stall_pattern[31]};
            if ($urandom_range(0, 255) == 0) pattern_next = $urandom;
            if ($urandom_range(0, 511) == 0) pattern_next = '0;
            stall_pattern <= pattern_next;
            m_ready <= ~stall_pattern[0];
        end
    end

    // Watchdog: end the run when nothing has been accepted for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        stall_pattern = 32'h0F0F_0033;
        mismatches = 0;
        results_seen = 0;
        items_sent = 0;
        idle_cycles = 0;
        settings_used = 0;
        mode_count_q = 3'd2;
        unfold_mode_q = 2'd0;
        for (int i = 0; i < FIELD_MODES; i++) extent_q[i] = 1;
        rebuild_strides();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // Reset configuration first, then the sweep.
        test_extremes();
        test_random_block(40);
        test_settings();
        test_random_settings(9);
        drain();
        $display("Sent %0d items over %0d settings, %0d results checked.",
                 items_sent, settings_used, results_seen);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches, %0d results missing.", mismatches,
                     expected_results.size());
            $display("FAILURE");
        end
        $finish;
    end
endmodule

/* files.f */
sv/tuim_pkg.sv
sv/tuim_cfg.sv
sv/tuim_front.sv
sv/tuim_div.sv
sv/tensor_unfold_index_map_core.sv
sv/tuim_checker.sv
tb/tb_tensor_unfold_index_map_core.sv
